// ===== hdl/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue package
// Shared widths, codes, the cell command and link types and the sequencer states.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int CELL_NUM   = TASK_SLOTS;
  localparam int TASK_W     = 6;
  localparam int SLOT_NUM   = 2 ** TASK_W;
  localparam int TIME_W     = 63;
  localparam int NS_W       = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [NS_W-1:0] SLICE_RESET = NS_W'(10000000);
  localparam logic [NS_W-1:0] SLOP_RESET  = NS_W'(50000);

  localparam logic [CFG_IDX_W-1:0] REG_SLICE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLOP  = CFG_IDX_W'(1);

  typedef logic [TASK_W-1:0] task_t;

  typedef enum logic [1:0] {
    KIND_SCHED = 2'd0,
    KIND_WAKE  = 2'd1,
    KIND_SLEEP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESCHED = 2'd1,
    ACT_TIMER   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_APPEND,
    OP_PUSH
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    task_t    key;
  } cell_cmd_t;

  typedef struct packed {
    task_t slot;
    logic  vld;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_RESULT
  } state_t;

endpackage

// ===== hdl/rrq_cell.sv =====
// ----------------------------------------------------------------------------
// Run queue cell
// One place of the ordered queue: a slot number and an occupied flag, moved
// left, right or filled in step with its neighbours.
// ----------------------------------------------------------------------------
module rrq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rrq_pkg::cell_cmd_t cmd,
  input  rrq_pkg::cell_link_t left_i,
  input  rrq_pkg::cell_link_t right_i,
  input  logic               found_i,
  output rrq_pkg::cell_link_t q_o,
  output logic               found_o
);
  import rrq_pkg::*;

  task_t slot_r;
  task_t slot_nxt;
  logic  vld_r;
  logic  vld_nxt;
  logic  match;

  assign match   = vld_r && (slot_r == cmd.key);
  assign found_o = found_i | match;
  assign q_o     = '{slot: slot_r, vld: vld_r};

  always_comb begin
    slot_nxt = slot_r;
    vld_nxt  = vld_r;
    case (cmd.op)
      OP_REMOVE: begin
        // close the gap: everything from the match onwards moves left
        if (found_o) begin
          slot_nxt = right_i.slot;
          vld_nxt  = right_i.vld;
        end
      end
      OP_APPEND: begin
        if (!vld_r && left_i.vld) begin
          slot_nxt = cmd.key;
          vld_nxt  = 1'b1;
        end
      end
      OP_PUSH: begin
        slot_nxt = left_i.slot;
        vld_nxt  = left_i.vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ===== hdl/round_robin_run_queue.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue
// Ordered run queue held in a row of cells, with schedule, wake and sleep.
// ----------------------------------------------------------------------------
// Each word runs through the REMOVE, INSERT and RESULT states: start is taken
// while busy is low, the queue row is shifted to remove the task in the next
// cycle, shifted again to append or push in the cycle after, and the result
// word is computed in RESULT and shown with out_valid for one cycle after it,
// when busy has already dropped. The result cannot be held off: out_valid
// marks it for exactly one cycle. The queue is empty after reset with no
// clearing pass, and the head of the queue always sits in the first cell.
// Configuration writes take effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
module round_robin_run_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_kind,
  input  logic [rrq_pkg::TASK_W-1:0]         in_task_req,
  input  logic                               in_task_runnable,
  input  logic                               in_task_running,
  input  logic [rrq_pkg::TIME_W-1:0]         in_now_ns,
  input  logic [rrq_pkg::TIME_W-1:0]         in_curr_last_dispatch,
  input  logic [rrq_pkg::NS_W-1:0]           in_curr_min_slice,
  input  logic                               in_curr_is_idle,
  input  logic [rrq_pkg::TIME_W-1:0]         in_timer_expiry,
  output logic                               out_valid,
  output logic [rrq_pkg::TASK_W-1:0]         out_next_task,
  output logic                               out_next_valid,
  output logic [rrq_pkg::NS_W-1:0]           out_slice_out,
  output logic [1:0]                         out_action,
  output logic [rrq_pkg::TIME_W-1:0]         out_timer_value,
  input  logic                               cfg_we,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrq_pkg::NS_W-1:0]           cfg_wdata
);
  import rrq_pkg::*;

  state_t              state_r;
  state_t              state_nxt;
  logic                accept;

  logic [1:0]          kind_r;
  task_t               task_r;
  logic                runnable_r;
  logic                running_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   last_r;
  logic [NS_W-1:0]     owed_ns_r;
  logic                idle_r;
  logic [TIME_W-1:0]   expiry_r;

  logic                do_wake_r;
  logic [TIME_W:0]     min_time_r;
  logic                early_r;
  logic [TIME_W+1:0]   sum2_r;

  logic [SLOT_NUM-1:0] queued_r;
  logic [SLOT_NUM-1:0] queued_nxt;
  logic                in_range;

  logic [NS_W-1:0]     slice_r;
  logic [NS_W-1:0]     slop_r;

  cell_cmd_t           cmd;
  cell_link_t          cell_q [CELL_NUM];
  logic                found [CELL_NUM+1];

  logic                out_valid_r;
  task_t               out_task_r;
  task_t               out_task_nxt;
  logic                out_nvalid_r;
  logic                out_nvalid_nxt;
  logic [NS_W-1:0]     out_slice_r;
  logic [NS_W-1:0]     out_slice_nxt;
  logic [1:0]          out_action_r;
  logic [1:0]          out_action_nxt;
  logic [TIME_W-1:0]   out_timer_r;
  logic [TIME_W-1:0]   out_timer_nxt;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(task_r) < TASK_SLOTS);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= SLICE_RESET;
      slop_r  <= SLOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICE: slice_r <= cfg_wdata;
        REG_SLOP:  slop_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // ---- captured word ----
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      task_r      <= in_task_req;
      runnable_r  <= in_task_runnable;
      running_r   <= in_task_running;
      now_r       <= in_now_ns;
      last_r      <= in_curr_last_dispatch;
      owed_ns_r   <= in_curr_min_slice;
      idle_r      <= in_curr_is_idle;
      expiry_r    <= in_timer_expiry;
    end
  end

  // ---- wake timing, adds and compares registered in the remove and insert states ----
  always_ff @(posedge clk) begin
    if (state_r == ST_REMOVE) begin
      do_wake_r  <= (kind_r == KIND_WAKE) && in_range && !queued_r[task_r];
      min_time_r <= {1'b0, last_r} + (TIME_W+1)'(owed_ns_r);
    end
    if (state_r == ST_INSERT) begin
      early_r <= idle_r || (min_time_r <= {1'b0, now_r});
      sum2_r  <= {1'b0, min_time_r} + (TIME_W+2)'(slop_r);
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      queued_r <= '0;
    end else begin
      state_r  <= state_nxt;
      queued_r <= queued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    queued_nxt = queued_r;
    cmd.op     = OP_HOLD;
    cmd.key    = task_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        state_nxt = ST_INSERT;
        if (in_range && queued_r[task_r] &&
            ((kind_r == KIND_SCHED) || ((kind_r == KIND_SLEEP) && !running_r))) begin
          cmd.op              = OP_REMOVE;
          queued_nxt[task_r]  = 1'b0;
        end
      end
      ST_INSERT: begin
        state_nxt = ST_RESULT;
        if (in_range && (kind_r == KIND_SCHED) && runnable_r) begin
          cmd.op             = OP_APPEND;
          queued_nxt[task_r] = 1'b1;
        end else if (do_wake_r) begin
          cmd.op             = OP_PUSH;
          queued_nxt[task_r] = 1'b1;
        end
      end
      ST_RESULT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- queue row: first cell is the head ----
  assign found[0] = 1'b0;

  for (genvar i = 0; i < CELL_NUM; i++) begin : g_cell
    cell_link_t left_w;
    cell_link_t right_w;

    if (i == 0) begin : g_first
      // a push feeds the new task in from the left
      assign left_w = '{slot: cmd.key, vld: 1'b1};
    end else begin : g_mid
      assign left_w = cell_q[i-1];
    end

    if (i == CELL_NUM-1) begin : g_last
      assign right_w = '{slot: '0, vld: 1'b0};
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end

    rrq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .found_i (found[i]),
      .q_o     (cell_q[i]),
      .found_o (found[i+1])
    );
  end

  // ---- result word ----
  always_comb begin
    out_task_nxt   = '0;
    out_nvalid_nxt = 1'b0;
    out_slice_nxt  = '0;
    out_action_nxt = ACT_NONE;
    out_timer_nxt  = '0;
    unique case (kind_r)
      KIND_SCHED: begin
        if (cell_q[0].vld) begin
          out_task_nxt   = cell_q[0].slot;
          out_nvalid_nxt = 1'b1;
          out_slice_nxt  = slice_r;
        end
      end
      KIND_WAKE: begin
        if (do_wake_r) begin
          if (early_r) begin
            out_action_nxt = ACT_RESCHED;
          end else if ({2'b00, expiry_r} > sum2_r) begin
            out_action_nxt = ACT_TIMER;
            out_timer_nxt  = min_time_r[TIME_W-1:0];
          end
        end
      end
      KIND_SLEEP: begin
        if (running_r) begin
          out_action_nxt = ACT_RESCHED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_RESULT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT) begin
      out_task_r   <= out_task_nxt;
      out_nvalid_r <= out_nvalid_nxt;
      out_slice_r  <= out_slice_nxt;
      out_action_r <= out_action_nxt;
      out_timer_r  <= out_timer_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_task   = out_task_r;
  assign out_next_valid  = out_nvalid_r;
  assign out_slice_out   = out_slice_r;
  assign out_action      = out_action_r;
  assign out_timer_value = out_timer_r;

endmodule

// ===== bench/round_robin_run_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Round-robin run queue testbench
// Drives schedule, wake and sleep words through the command port and checks
// every result word against a local run queue model: an ordered list of
// queued slots plus the two timing registers. A short directed sequence opens
// the run, then random phases follow, each under its own register setting.
// ----------------------------------------------------------------------------
module round_robin_run_queue_tb;
  import rrq_pkg::*;

  localparam logic [1:0]        KIND_NONE     = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam int                PHASES        = 7;
  localparam int                PHASE_WORDS   = 250;
  localparam int                SETTLE_CYCLES = 8;
  localparam int                CYCLE_LIMIT   = 400000;
  localparam int                POOL_SPAN [PHASES] = '{6, 12, 64, 4, 24, 64, 10};
  localparam int                WAKE_PCT  [PHASES] = '{40, 35, 55, 30, 45, 40, 35};
  localparam int                GAP_PCT   [PHASES] = '{30, 0, 40, 60, 25, 35, 0};

  typedef struct {
    logic [1:0]        kind;
    task_t             task_id;
    logic              runnable;
    logic              running;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] last;
    logic [NS_W-1:0]   owed_ns;
    logic              idle;
    logic [TIME_W-1:0] expiry;
  } sched_word_t;

  typedef struct packed {
    task_t             next_task;
    logic              next_valid;
    logic [NS_W-1:0]   slice_out;
    action_t           action;
    logic [TIME_W-1:0] timer_value;
  } outcome_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]           in_kind               = '0;
  task_t                in_task_req           = '0;
  logic                 in_task_runnable      = 1'b0;
  logic                 in_task_running       = 1'b0;
  logic [TIME_W-1:0]    in_now_ns             = '0;
  logic [TIME_W-1:0]    in_curr_last_dispatch = '0;
  logic [NS_W-1:0]      in_curr_min_slice     = '0;
  logic                 in_curr_is_idle       = 1'b0;
  logic [TIME_W-1:0]    in_timer_expiry       = '0;
  logic                 out_valid;
  task_t                out_next_task;
  logic                 out_next_valid;
  logic [NS_W-1:0]      out_slice_out;
  logic [1:0]           out_action;
  logic [TIME_W-1:0]    out_timer_value;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLICE;
  logic [NS_W-1:0]      cfg_wdata = '0;

  // model state: queue order from head to tail, and the two registers
  task_t           run_order[$];
  logic [NS_W-1:0] slice_reg = SLICE_RESET;
  logic [NS_W-1:0] slop_reg  = SLOP_RESET;

  sched_word_t word_backlog[$];
  sched_word_t word_on_bus;
  outcome_t    due_results[$];
  outcome_t    head_want;
  int          words_queued = 0;
  int          words_taken  = 0;
  int          gap_left     = 0;
  int          gap_pct      = 0;
  int          mismatches   = 0;
  int          cycle_cnt    = 0;

  round_robin_run_queue i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_task_req           (in_task_req),
    .in_task_runnable      (in_task_runnable),
    .in_task_running       (in_task_running),
    .in_now_ns             (in_now_ns),
    .in_curr_last_dispatch (in_curr_last_dispatch),
    .in_curr_min_slice     (in_curr_min_slice),
    .in_curr_is_idle       (in_curr_is_idle),
    .in_timer_expiry       (in_timer_expiry),
    .out_valid             (out_valid),
    .out_next_task         (out_next_task),
    .out_next_valid        (out_next_valid),
    .out_slice_out         (out_slice_out),
    .out_action            (out_action),
    .out_timer_value       (out_timer_value),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial forever #2 clk = ~clk;

  function automatic int queue_pos(task_t id);
    for (int i = 0; i < run_order.size(); i++)
      if (run_order[i] == id) return i;
    return -1;
  endfunction

  // Apply one word to the model and return the result word it yields.
  function automatic outcome_t advance_run_queue(sched_word_t w);
    outcome_t   o;
    int         pos;
    logic [64:0] min_end;
    o = '0;
    pos = queue_pos(w.task_id);
    case (w.kind)
      KIND_SCHED: begin
        if (pos >= 0) run_order.delete(pos);
        if (w.runnable) run_order.push_back(w.task_id);
        if (run_order.size() != 0) begin
          o.next_task  = run_order[0];
          o.next_valid = 1'b1;
          o.slice_out  = slice_reg;
        end
      end
      KIND_WAKE: begin
        if (pos < 0) begin
          run_order.push_front(w.task_id);
          // sum wide so that the earliest end and the slip never wrap
          min_end = 65'(w.last) + 65'(w.owed_ns);
          if (w.idle || min_end <= 65'(w.now)) begin
            o.action = ACT_RESCHED;
          end else if (65'(w.expiry) > min_end + 65'(slop_reg)) begin
            o.action      = ACT_TIMER;
            o.timer_value = min_end[TIME_W-1:0];
          end
        end
      end
      KIND_SLEEP: begin
        if (w.running) o.action = ACT_RESCHED;
        else if (pos >= 0) run_order.delete(pos);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 3))
      0:       return TIME_W'($urandom_range(0, 5000));
      1:       return TIME_MAX - TIME_W'($urandom_range(0, 5000));
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic void push_word(logic [1:0] kind, task_t id, logic runnable,
                                    logic running, logic [TIME_W-1:0] now,
                                    logic [TIME_W-1:0] last, logic [NS_W-1:0] owed_ns,
                                    logic idle, logic [TIME_W-1:0] expiry);
    sched_word_t w;
    w = '{kind, id, runnable, running, now, last, owed_ns, idle, expiry};
    word_backlog.push_back(w);
    words_queued++;
  endfunction

  function automatic sched_word_t make_random_word(task_t base, int span, int wake_pct);
    sched_word_t w;
    int          pick;
    logic [63:0] min_end;
    pick = $urandom_range(0, 99);
    w.kind = (pick < 3) ? KIND_NONE : (pick < 20) ? KIND_SLEEP :
             (pick < 20 + wake_pct) ? KIND_WAKE : KIND_SCHED;
    w.task_id = ($urandom_range(0, 9) == 0) ? task_t'($urandom) :
                task_t'(base + task_t'($urandom_range(0, span - 1)));
    w.runnable  = $urandom_range(0, 3) != 0;
    w.running   = $urandom_range(0, 3) == 0;
    w.now       = rand_time();
    w.last      = rand_time();
    w.expiry    = rand_time();
    w.owed_ns   = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 100000);
    w.idle      = $urandom_range(0, 6) == 0;
    if (w.kind == KIND_WAKE && $urandom_range(0, 2) != 0) begin
      // land near the reschedule and reprogram boundaries
      min_end  = 64'(w.last) + 64'(w.owed_ns);
      w.now    = TIME_W'(min_end + 64'($urandom_range(0, 4)) - 64'd2);
      w.expiry = TIME_W'(min_end + 64'(slop_reg) + 64'($urandom_range(0, 4)) - 64'd2);
    end
    return w;
  endfunction

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  task automatic wait_drained();
    while (words_taken != words_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [NS_W-1:0] slice, logic [NS_W-1:0] slop);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SLICE;
    cfg_wdata <= slice;
    @(posedge clk);
    cfg_index <= REG_SLOP;
    cfg_wdata <= slop;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_reg = slice;
    slop_reg  = slop;
  endtask

  // driver: offer the next word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        due_results.push_back(advance_run_queue(word_on_bus));
        words_taken++;
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        word_on_bus = word_backlog.pop_front();
        start                 <= 1'b1;
        in_kind               <= word_on_bus.kind;
        in_task_req           <= word_on_bus.task_id;
        in_task_runnable      <= word_on_bus.runnable;
        in_task_running       <= word_on_bus.running;
        in_now_ns             <= word_on_bus.now;
        in_curr_last_dispatch <= word_on_bus.last;
        in_curr_min_slice     <= word_on_bus.owed_ns;
        in_curr_is_idle       <= word_on_bus.idle;
        in_timer_expiry       <= word_on_bus.expiry;
        if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobed word is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("unexpected word: task %0d valid %0d slice %0d action %0d",
                               out_next_task, out_next_valid, out_slice_out, out_action));
      end else begin
        head_want = due_results.pop_front();
        if (out_next_task !== head_want.next_task || out_next_valid !== head_want.next_valid ||
            out_slice_out !== head_want.slice_out || out_action !== head_want.action ||
            out_timer_value !== head_want.timer_value)
          log_mismatch($sformatf(
            "want task %0d valid %0d slice %0d action %0d timer %0d, got %0d %0d %0d %0d %0d",
            head_want.next_task, head_want.next_valid, head_want.slice_out, head_want.action,
            head_want.timer_value, out_next_task, out_next_valid, out_slice_out, out_action,
            out_timer_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [NS_W-1:0] slice_set [PHASES];
    logic [NS_W-1:0] slop_set  [PHASES];
    task_t           pool_base;
    slice_set = '{SLICE_RESET, '0, '1, $urandom, 32'd1, $urandom, SLICE_RESET};
    slop_set  = '{SLOP_RESET, '0, '1, $urandom, '1, $urandom_range(0, 100000), SLOP_RESET};

    // empty queue, misses and hits on every path, then list edits at each end
    push_word(KIND_SCHED, 6'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd5, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd5, 1'b0, 1'b1, '0, '0, '0, 1'b0, '0);
    push_word(KIND_WAKE, 6'd63, 1'b0, 1'b0, '0, '0, '0, 1'b1, '0);
    push_word(KIND_WAKE, 6'd63, 1'b0, 1'b0, '0, 63'd5, 32'd5, 1'b0, TIME_MAX);
    push_word(KIND_WAKE, 6'd0, 1'b0, 1'b0, 63'd2000, 63'd1000, 32'd1000, 1'b0, TIME_MAX);
    push_word(KIND_WAKE, 6'd10, 1'b0, 1'b0, 63'd1000, 63'd1000, 32'd500, 1'b0, 63'd51501);
    push_word(KIND_WAKE, 6'd11, 1'b0, 1'b0, 63'd1000, 63'd1000, 32'd500, 1'b0, 63'd51500);
    push_word(KIND_WAKE, 6'd12, 1'b0, 1'b0, TIME_MAX, TIME_MAX, '1, 1'b0, TIME_MAX);
    push_word(KIND_WAKE, 6'd13, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd0, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd13, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd40, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd10, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd40, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd12, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_NONE, 6'd63, 1'b1, 1'b1, TIME_MAX, TIME_MAX, '1, 1'b1, TIME_MAX);
    push_word(KIND_SCHED, 6'd11, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SLEEP, 6'd33, 1'b0, 1'b1, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd63, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd11, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    push_word(KIND_SCHED, 6'd21, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      // hold the sender until every result is in, then retune the registers
      if (ph != 0) begin
        wait_drained();
        write_regs(slice_set[ph], slop_set[ph]);
      end
      gap_pct   = GAP_PCT[ph];
      pool_base = task_t'($urandom);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        word_backlog.push_back(make_random_word(pool_base, POOL_SPAN[ph], WAKE_PCT[ph]));
        words_queued++;
      end
    end

    wait_drained();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
